/* hdl/utf8_substring_position_finder_core_defines.svh */
// ----------------------------------------------------------------------------
// utf8_substring_position_finder_core_defines.svh
// Assertion macros shared by the substring position finder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_SUBSTRING_POSITION_FINDER_CORE_DEFINES_SVH
`define UTF8_SUBSTRING_POSITION_FINDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define USFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define USFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/usfp_pkg.sv */
// ----------------------------------------------------------------------------
// usfp_pkg
// Shared types and constants of the substring position finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package usfp_pkg;

    // Input beat kinds
    typedef enum logic [1:0] {
        OP_NEEDLE = 2'd0,
        OP_HAY    = 2'd1,
        OP_END    = 2'd2,
        OP_NULL   = 2'd3
    } op_t;

    localparam int          BYTE_BITS = 8;
    // UTF-8 continuation byte is 10xxxxxx
    localparam logic [7:0]  CONT_MASK = 8'hC0;
    localparam logic [7:0]  CONT_BITS = 8'h80;

    // Controls broadcast to every window cell
    typedef struct packed {
        logic                 clear;
        logic                 shift;
        logic [BYTE_BITS-1:0] hay_byte;
    } cell_ctl_t;

endpackage

/* hdl/usfp_cell.sv */
// ----------------------------------------------------------------------------
// usfp_cell
// One window cell: a needle byte, a running prefix-match bit and the
// character number at which that partial match began.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usfp_cell #(
    parameter int POSITION_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  usfp_pkg::cell_ctl_t                ctl,
    input  logic                               load,
    input  logic [usfp_pkg::BYTE_BITS-1:0]     load_byte,
    input  logic                               prev_match,
    input  logic [POSITION_BITS-1:0]           prev_num,
    output logic                               match,
    output logic [POSITION_BITS-1:0]           num
);

    logic [usfp_pkg::BYTE_BITS-1:0] needle_reg;
    logic [usfp_pkg::BYTE_BITS-1:0] needle_next;
    logic                           match_reg;
    logic                           match_next;
    logic [POSITION_BITS-1:0]       num_reg;
    logic [POSITION_BITS-1:0]       num_next;

    // Prefix match extends by one byte per haystack beat
    always_comb
    begin
        needle_next = load ? load_byte : needle_reg;
        num_next    = ctl.shift ? prev_num : num_reg;
        if (ctl.clear)
        begin
            match_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            match_next = prev_match && (ctl.hay_byte == needle_reg);
        end
        else
        begin
            match_next = match_reg;
        end
    end

    // Control bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        needle_reg <= needle_next;
        num_reg    <= num_next;
    end

    assign match = match_reg;
    assign num   = num_reg;

endmodule

/* hdl/utf8_substring_position_finder_core.sv */
// ----------------------------------------------------------------------------
// utf8_substring_position_finder_core
// First-occurrence substring search over a streamed haystack, SQL instr()
// style, with UTF-8 character or raw byte positions.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata            tuser                  tlast
//  s_*       in   data_byte[7:0]   op[1:0], text_mode[2]  -
//  m_*       out  position[31:0]   is_null[0]             -
//
//  One beat per cycle is accepted while s_tready is high. The haystack
//  advances through a chain of NEEDLE_MAX cells, each extending a prefix
//  match by one byte per beat, so a match is known the cycle after its
//  last byte. The result of an end or null beat appears on m_* the next
//  cycle. s_tready drops only while a result is held and m_tready is low.
//  Reset is asynchronous, active low, and leaves the block empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_substring_position_finder_core_defines.svh"

module utf8_substring_position_finder_core #(
    parameter int NEEDLE_MAX    = 32,
    parameter int POSITION_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_tuser,   // [1:0] op, [2] text_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] position
    output logic [0:0]  m_tuser    // [0] is_null
);

    localparam int                   NC_BITS = $clog2(NEEDLE_MAX + 1);
    localparam int                   OUT_BITS = 32;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    usfp_pkg::op_t             op;
    logic                      text_mode;
    logic                      in_acc;
    logic                      start;
    usfp_pkg::cell_ctl_t       ctl;

    logic [NC_BITS-1:0]        needle_count_reg;
    logic [NC_BITS-1:0]        needle_count_next;
    logic [POSITION_BITS-1:0]  char_counter_reg;
    logic [POSITION_BITS-1:0]  char_counter_next;
    logic                      match_found_reg;
    logic                      match_found_next;
    logic [POSITION_BITS-1:0]  match_pos_reg;
    logic [POSITION_BITS-1:0]  match_pos_next;

    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [OUT_BITS-1:0]       m_data_reg;
    logic [OUT_BITS-1:0]       m_data_next;
    logic                      m_user_reg;
    logic                      m_user_next;

    logic                      load_ok;
    logic                      match_w [NEEDLE_MAX];
    logic [POSITION_BITS-1:0]  num_w   [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0]     last_mask;
    logic                      found_now;
    logic [POSITION_BITS-1:0]  sel_num;
    logic [POSITION_BITS-1:0]  pos_full;
    logic [POSITION_BITS+OUT_BITS-1:0] pos_ext;

    // Input decode and handshake
    assign op        = usfp_pkg::op_t'(s_tuser[1:0]);
    assign text_mode = s_tuser[2];
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;

    // First haystack byte always counts as a character start
    assign start = (char_counter_reg == '0) || !text_mode ||
                   ((s_tdata & usfp_pkg::CONT_MASK) != usfp_pkg::CONT_BITS);

    assign ctl.clear    = in_acc && ((op == usfp_pkg::OP_END) || (op == usfp_pkg::OP_NULL));
    assign ctl.shift    = in_acc && (op == usfp_pkg::OP_HAY);
    assign ctl.hay_byte = s_tdata;

    // Needle bytes only before the first haystack byte, up to NEEDLE_MAX
    assign load_ok = in_acc && (op == usfp_pkg::OP_NEEDLE) && (char_counter_reg == '0) &&
                     (needle_count_reg < NC_BITS'(NEEDLE_MAX));

    // Cell chain
    for (genvar k = 0; k < NEEDLE_MAX; k++)
    begin : g_cell
        logic                     prev_match;
        logic [POSITION_BITS-1:0] prev_num;

        if (k == 0)
        begin : g_head
            assign prev_match = start;
            assign prev_num   = char_counter_next;
        end
        else
        begin : g_body
            assign prev_match = match_w[k-1];
            assign prev_num   = num_w[k-1];
        end

        assign last_mask[k] = (needle_count_reg == NC_BITS'(k + 1));

        usfp_cell #(
            .POSITION_BITS (POSITION_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .load       (load_ok && (needle_count_reg == NC_BITS'(k))),
            .load_byte  (s_tdata),
            .prev_match (prev_match),
            .prev_num   (prev_num),
            .match      (match_w[k]),
            .num        (num_w[k])
        );
    end

    // Pick the cell that holds a full needle match
    always_comb
    begin
        found_now = 1'b0;
        sel_num   = '0;
        for (int k = 0; k < NEEDLE_MAX; k++)
        begin
            found_now = found_now | (match_w[k] & last_mask[k]);
            sel_num   = sel_num | (num_w[k] & {POSITION_BITS{last_mask[k]}});
        end
    end

    // Call state and result
    always_comb
    begin
        needle_count_next = needle_count_reg;
        char_counter_next = char_counter_reg;
        match_found_next  = match_found_reg || found_now;
        match_pos_next    = match_found_reg ? match_pos_reg : sel_num;
        m_valid_next      = m_valid_reg && !m_tready;
        m_data_next       = m_data_reg;
        m_user_next       = m_user_reg;

        if (needle_count_reg == '0)
        begin
            pos_full = POSITION_BITS'(1);
        end
        else if (match_found_reg)
        begin
            pos_full = match_pos_reg;
        end
        else if (found_now)
        begin
            pos_full = sel_num;
        end
        else
        begin
            pos_full = '0;
        end
        pos_ext = {{OUT_BITS{1'b0}}, pos_full};

        if (load_ok)
        begin
            needle_count_next = needle_count_reg + NC_BITS'(1);
        end

        if (ctl.shift && start && (char_counter_reg != POS_MAX))
        begin
            char_counter_next = char_counter_reg + POSITION_BITS'(1);
        end

        if (in_acc)
        begin
            unique case (op) inside
                usfp_pkg::OP_NEEDLE,
                usfp_pkg::OP_HAY:
                begin
                end
                usfp_pkg::OP_END:
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = (|pos_ext[POSITION_BITS+OUT_BITS-1:OUT_BITS]) ?
                                   '1 : pos_ext[OUT_BITS-1:0];
                    m_user_next  = 1'b0;
                end
                usfp_pkg::OP_NULL:
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_user_next  = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (ctl.clear)
        begin
            needle_count_next = '0;
            char_counter_next = '0;
            match_found_next  = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_count_reg <= '0;
            char_counter_reg <= '0;
            match_found_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            needle_count_reg <= needle_count_next;
            char_counter_reg <= char_counter_next;
            match_found_reg  <= match_found_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        match_pos_reg <= match_pos_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    // Checks
    `USFP_ASSERT_IMPLY(a_last_onehot, clk, rst_n, 1'b1, $onehot0(last_mask),
        "more than one cell marked as needle end")
    `USFP_ASSERT_NEXT(a_null_result, clk, rst_n, in_acc && (op == usfp_pkg::OP_NULL),
        m_valid_reg && m_user_reg && (m_data_reg == '0), "null call gave no null result")
    `USFP_ASSERT_NEXT(a_call_cleared, clk, rst_n, ctl.clear,
        (needle_count_reg == '0) && (char_counter_reg == '0) && !match_found_reg,
        "call state not cleared after result")
    `USFP_ASSERT_IMPLY(a_match_needs_needle, clk, rst_n, match_found_reg,
        needle_count_reg != '0, "match recorded with empty needle")

endmodule
